FILE: rtl/core/rgb_led_chain_frame_packer_defines.svh
`ifndef RGB_LED_CHAIN_FRAME_PACKER_DEFINES_SVH
`define RGB_LED_CHAIN_FRAME_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RLCFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RLCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rlcfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlcfp_pkg;

    localparam int LED_COUNT_DEFAULT = 16;

    localparam int COLOUR_W = 10;
    localparam int ENTRY_W  = 3 * COLOUR_W;
    localparam int INDEX_W  = 5;
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_SET_ONE = 2'd0;
    localparam logic [1:0] MODE_SET_ALL = 2'd1;
    localparam logic [1:0] MODE_UPDATE  = 2'd2;

    localparam logic [1:0] CMD_COLOUR  = 2'b00;
    localparam logic [1:0] CMD_CORRECT = 2'b01;

    localparam logic [CFG_IDX_W-1:0] CFG_CORR_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_BLUE  = 2'd2;

    localparam logic [COLOUR_W-1:0] CORR_RED_RESET   = 10'd120;
    localparam logic [COLOUR_W-1:0] CORR_GREEN_RESET = 10'd100;
    localparam logic [COLOUR_W-1:0] CORR_BLUE_RESET  = 10'd100;

    typedef struct packed {
        logic [1:0]          mode;
        logic [INDEX_W-1:0]  led_index;
        logic [COLOUR_W-1:0] red_level;
        logic [COLOUR_W-1:0] green_level;
        logic [COLOUR_W-1:0] blue_level;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] packet_word;
        logic              latch_after;
        logic              last;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COLOUR,
        ST_CORR
    } seq_state_t;

    typedef struct packed {
        logic load_one;
        logic load_all;
        logic shift;
        logic emit_colour;
        logic emit_corr;
        logic phase_end;
    } seq_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rlcfp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rlcfp_cell
    import rlcfp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic [ENTRY_W-1:0] load_data,
    input  wire logic               shift,
    input  wire logic [ENTRY_W-1:0] shift_in,
    output logic      [ENTRY_W-1:0] entry
);

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;

    always_comb begin
        priority if (load) begin
            entry_next = load_data;
        end else if (shift) begin
            entry_next = shift_in;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rlcfp_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rlcfp_seq
    import rlcfp_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] mode,
    input  wire logic       adv,
    output logic            s_ready,
    output seq_ctrl_t       ctrl
);

    localparam int CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LED_COUNT - 1);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             at_last;

    assign accept  = s_valid && (state_reg == ST_IDLE);
    assign at_last = (cnt_reg == CNT_LAST);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (mode == MODE_UPDATE)) begin
                    state_next = ST_COLOUR;
                end
            end
            ST_COLOUR: begin
                if (adv && at_last) begin
                    state_next = ST_CORR;
                end
            end
            ST_CORR: begin
                if (adv && at_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        ctrl    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                ctrl.load_one = accept && (mode == MODE_SET_ONE);
                ctrl.load_all = accept && (mode == MODE_SET_ALL);
            end
            ST_COLOUR: begin
                ctrl.shift       = adv;
                ctrl.emit_colour = adv;
                ctrl.phase_end   = at_last;
            end
            ST_CORR: begin
                ctrl.emit_corr = adv;
                ctrl.phase_end = at_last;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.emit_colour || ctrl.emit_corr) begin
            cnt_next = at_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_led_chain_frame_packer.sv
// Set items produce no word; the next item is taken on the following cycle.
// With a ready sink an update sends its colour words off the head of the cell chain one per
// cycle, then the correction words, from one output register; a stalled sink holds the flow.
// Reset (aresetn low, synchronous) clears every cell to zero and loads the correction
// registers with 120, 100 and 100; the colour words of an update leave the chain all zero.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_led_chain_frame_packer_defines.svh"

module rgb_led_chain_frame_packer
    import rlcfp_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_word_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_word_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOUR_W-1:0]  cfg_data
);

    seq_ctrl_t          ctrl;
    logic               adv;
    logic [ENTRY_W-1:0] set_entry;
    logic [ENTRY_W-1:0] cell_q [LED_COUNT];

    logic [COLOUR_W-1:0] corr_red_reg;
    logic [COLOUR_W-1:0] corr_green_reg;
    logic [COLOUR_W-1:0] corr_blue_reg;

    out_word_t m_data_reg;
    out_word_t m_data_next;
    logic      m_valid_reg;
    logic      m_valid_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_red_reg   <= CORR_RED_RESET;
            corr_green_reg <= CORR_GREEN_RESET;
            corr_blue_reg  <= CORR_BLUE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_CORR_RED) begin
                corr_red_reg <= cfg_data;
            end
            if (cfg_index == CFG_CORR_GREEN) begin
                corr_green_reg <= cfg_data;
            end
            if (cfg_index == CFG_CORR_BLUE) begin
                corr_blue_reg <= cfg_data;
            end
        end
    end

    assign adv = !m_valid_reg || m_ready;

    rlcfp_seq #(
        .LED_COUNT (LED_COUNT)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .mode    (s_data.mode),
        .adv     (adv),
        .s_ready (s_ready),
        .ctrl    (ctrl)
    );

    assign set_entry = {s_data.blue_level, s_data.red_level, s_data.green_level};

    for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
        localparam logic [INDEX_W-1:0] CELL_IDX = INDEX_W'(i);
        logic               cell_load;
        logic [ENTRY_W-1:0] cell_in;

        assign cell_load = ctrl.load_all || (ctrl.load_one && (s_data.led_index == CELL_IDX));
        if (i == LED_COUNT - 1) begin : g_tail
            assign cell_in = '0;
        end else begin : g_link
            assign cell_in = cell_q[i+1];
        end

        rlcfp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (cell_load),
            .load_data (set_entry),
            .shift     (ctrl.shift),
            .shift_in  (cell_in),
            .entry     (cell_q[i])
        );
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (ctrl.emit_colour) begin
            m_data_next.packet_word = {CMD_COLOUR, cell_q[0]};
            m_data_next.latch_after = ctrl.phase_end;
            m_data_next.last        = 1'b0;
            m_valid_next            = 1'b1;
        end else if (ctrl.emit_corr) begin
            m_data_next.packet_word = {CMD_CORRECT, corr_blue_reg, corr_red_reg, corr_green_reg};
            m_data_next.latch_after = ctrl.phase_end;
            m_data_next.last        = ctrl.phase_end;
            m_valid_next            = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RLCFP_ASSERT_NOW(a_no_take_while_shifting, ctrl.shift, !s_ready,
        "input taken while the cell chain is shifting")
    `RLCFP_ASSERT_NOW(a_last_is_corr_latch, m_valid && m_data.last,
        (m_data.packet_word[31:30] == CMD_CORRECT) && m_data.latch_after,
        "final word is not a latched correction word")
    `RLCFP_ASSERT_NOW(a_colour_latch_cmd,
        m_valid && m_data.latch_after && !m_data.last,
        m_data.packet_word[31:30] == CMD_COLOUR,
        "colour latch mark on a word that is not a colour word")

endmodule

`default_nettype wire

FILE: verif/rgb_led_chain_frame_packer_tb.sv
`timescale 1ns / 1ps

module rgb_led_chain_frame_packer_tb;
    import rlcfp_pkg::*;

    localparam int LED_COUNT = LED_COUNT_DEFAULT;
    localparam int LED_IDX_W = $clog2(LED_COUNT);
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [COLOUR_W-1:0] LEVEL_MAX = 10'h3FF;
    localparam int SETTLE_CYCLES = 2 * LED_COUNT + 8;
    localparam int STALL_LIMIT = 3000;
    localparam int SINK_HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOUR_W-1:0] cfg_data = '0;

    in_word_t pending_items[$];
    out_word_t frame_words_due[$];
    int items_queued = 0;
    int items_accepted = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    bit no_idle = 1'b0;
    bit sink_hold_go = 1'b0;
    bit sink_hold_used = 1'b0;
    int sink_hold_left = 0;

    logic [ENTRY_W-1:0] led_colours[LED_COUNT];
    logic [COLOUR_W-1:0] corr_red = CORR_RED_RESET;
    logic [COLOUR_W-1:0] corr_green = CORR_GREEN_RESET;
    logic [COLOUR_W-1:0] corr_blue = CORR_BLUE_RESET;

    rgb_led_chain_frame_packer #(
        .LED_COUNT(LED_COUNT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // A set item updates the colour table; an update item yields the colour words, then the
    // correction words, and leaves the table cleared.
    task automatic predict_frame(input in_word_t w);
        int i;
        out_word_t word;
        case (w.mode)
            MODE_SET_ONE: begin
                if (w.led_index < LED_COUNT) begin
                    led_colours[w.led_index[LED_IDX_W-1:0]] =
                        {w.blue_level, w.red_level, w.green_level};
                end
            end
            MODE_SET_ALL: begin
                for (i = 0; i < LED_COUNT; i++) begin
                    led_colours[i] = {w.blue_level, w.red_level, w.green_level};
                end
            end
            MODE_UPDATE: begin
                for (i = 0; i < LED_COUNT; i++) begin
                    word.packet_word = {CMD_COLOUR, led_colours[i]};
                    word.latch_after = (i == LED_COUNT - 1);
                    word.last = 1'b0;
                    frame_words_due.push_back(word);
                end
                for (i = 0; i < LED_COUNT; i++) begin
                    word.packet_word = {CMD_CORRECT, corr_blue, corr_red, corr_green};
                    word.latch_after = (i == LED_COUNT - 1);
                    word.last = (i == LED_COUNT - 1);
                    frame_words_due.push_back(word);
                end
                for (i = 0; i < LED_COUNT; i++) begin
                    led_colours[i] = '0;
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic in_word_t make_item(input logic [1:0] mode, input logic [4:0] idx,
                                           input logic [9:0] red, input logic [9:0] green,
                                           input logic [9:0] blue);
        in_word_t w;
        w.mode = mode;
        w.led_index = idx;
        w.red_level = red;
        w.green_level = green;
        w.blue_level = blue;
        return w;
    endfunction

    function automatic logic [COLOUR_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            return '0;
        end else if (roll < 24) begin
            return LEVEL_MAX;
        end
        return COLOUR_W'($urandom_range(1023));
    endfunction

    function automatic in_word_t random_item();
        int roll;
        logic [1:0] mode;
        logic [4:0] idx;
        roll = $urandom_range(99);
        if (roll < 62) begin
            mode = MODE_SET_ONE;
        end else if (roll < 72) begin
            mode = MODE_SET_ALL;
        end else if (roll < 92) begin
            mode = MODE_UPDATE;
        end else begin
            mode = MODE_UNUSED;
        end
        if ($urandom_range(99) < 88) begin
            idx = INDEX_W'($urandom_range(LED_COUNT - 1));
        end else begin
            idx = INDEX_W'($urandom_range(31, LED_COUNT));
        end
        return make_item(mode, idx, pick_level(), pick_level(), pick_level());
    endfunction

    task automatic queue_item(input in_word_t w);
        pending_items.push_back(w);
        items_queued++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (items_accepted != items_queued || frame_words_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_correction(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COLOUR_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_CORR_RED: corr_red = value;
            CFG_CORR_GREEN: corr_green = value;
            CFG_CORR_BLUE: corr_blue = value;
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic random_corrections();
        write_correction(CFG_CORR_RED, pick_level());
        write_correction(CFG_CORR_GREEN, pick_level());
        write_correction(CFG_CORR_BLUE, pick_level());
        if ($urandom_range(1) == 1) begin
            write_correction(CFG_UNUSED, pick_level());
        end
    endtask

    always @(posedge aclk) begin
        logic next_valid;
        in_word_t next_word;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_word = s_data;
            if (s_valid && s_ready) begin
                predict_frame(s_data);
                items_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_items.size() != 0 &&
                (no_idle || $urandom_range(99) >= 7)) begin
                next_word = pending_items.pop_front();
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
            s_data <= next_word;
        end
    end

    always @(posedge aclk) begin
        out_word_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_words_due.size() == 0) begin
                    $display("%0t: unexpected word %h latch %b last %b", $time,
                             m_data.packet_word, m_data.latch_after, m_data.last);
                    mismatches++;
                end else begin
                    due = frame_words_due.pop_front();
                    if (m_data.packet_word !== due.packet_word) begin
                        $display("%0t: packet_word expected %h actual %h", $time,
                                 due.packet_word, m_data.packet_word);
                        mismatches++;
                    end
                    if (m_data.latch_after !== due.latch_after) begin
                        $display("%0t: latch_after expected %b actual %b", $time,
                                 due.latch_after, m_data.latch_after);
                        mismatches++;
                    end
                    if (m_data.last !== due.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 due.last, m_data.last);
                        mismatches++;
                    end
                end
            end
            if (sink_hold_left != 0) begin
                m_ready <= 1'b0;
                sink_hold_left <= sink_hold_left - 1;
            end else if (sink_hold_go && !sink_hold_used) begin
                m_ready <= 1'b0;
                sink_hold_left <= SINK_HOLD_CYCLES;
                sink_hold_used <= 1'b1;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 7);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("rgb_led_chain_frame_packer verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int p;
        int n;
        for (n = 0; n < LED_COUNT; n++) begin
            led_colours[n] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
        queue_item(make_item(MODE_SET_ONE, 5'd0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        queue_item(make_item(MODE_SET_ONE, 5'd15, LEVEL_MAX, '0, '0));
        queue_item(make_item(MODE_SET_ONE, 5'd7, '0, LEVEL_MAX, '0));
        queue_item(make_item(MODE_SET_ONE, 5'd8, '0, '0, LEVEL_MAX));
        queue_item(make_item(MODE_SET_ONE, 5'd16, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        queue_item(make_item(MODE_SET_ONE, 5'd31, 10'h155, 10'h2AA, 10'h155));
        queue_item(make_item(MODE_UNUSED, 5'd3, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        queue_item(make_item(MODE_UPDATE, 5'd31, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
        queue_item(make_item(MODE_SET_ALL, 5'd31, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
        queue_item(make_item(MODE_SET_ONE, 5'd3, 10'h155, 10'h2AA, 10'h0F0));
        queue_item(make_item(MODE_SET_ONE, 5'd20, '0, '0, '0));
        queue_item(make_item(MODE_UPDATE, 5'd10, '0, '0, '0));
        queue_item(make_item(MODE_SET_ALL, 5'd0, 10'h2AA, 10'h155, 10'h3C3));
        queue_item(make_item(MODE_UNUSED, 5'd0, '0, '0, '0));
        queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
        wait_drained();

        write_correction(CFG_CORR_RED, LEVEL_MAX);
        write_correction(CFG_CORR_GREEN, LEVEL_MAX);
        write_correction(CFG_CORR_BLUE, LEVEL_MAX);
        write_correction(CFG_UNUSED, '0);
        queue_item(make_item(MODE_SET_ONE, 5'd5, 10'h0A5, 10'h35A, 10'h1FF));
        queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
        wait_drained();

        write_correction(CFG_CORR_RED, '0);
        write_correction(CFG_CORR_GREEN, '0);
        write_correction(CFG_CORR_BLUE, '0);
        write_correction(CFG_UNUSED, LEVEL_MAX);
        queue_item(make_item(MODE_SET_ALL, 5'd0, 10'h001, 10'h200, 10'h3FE));
        queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
        wait_drained();

        for (p = 0; p < 4; p++) begin
            random_corrections();
            no_idle = (p == 2);
            for (n = 0; n < 55; n++) begin
                queue_item(random_item());
            end
            queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
            wait_drained();
        end
        no_idle = 1'b0;

        // Hold the sink off while updates keep arriving so the block backs up into its input.
        random_corrections();
        sink_hold_go = 1'b1;
        for (n = 0; n < 8; n++) begin
            queue_item(make_item(MODE_SET_ONE, INDEX_W'($urandom_range(LED_COUNT - 1)),
                                 pick_level(), pick_level(), pick_level()));
            queue_item(make_item(MODE_UPDATE, 5'd0, '0, '0, '0));
        end
        wait_drained();

        if (mismatches == 0) begin
            $display("rgb_led_chain_frame_packer verification clean");
        end else begin
            $display("rgb_led_chain_frame_packer verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rlcfp_pkg.sv
rtl/core/rlcfp_cell.sv
rtl/core/rlcfp_seq.sv
rtl/core/rgb_led_chain_frame_packer.sv
verif/rgb_led_chain_frame_packer_tb.sv
